[sv/prac_pkg.sv]
package prac_pkg;

  localparam int GUARD_BITS   = 4;
  localparam int ANGLE_W      = 32;
  localparam int ATAN_ENTRIES = 24;
  localparam int INDEX_W      = 10;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ANGLE_W  = 16;
  // low part width of the split gain multiply
  localparam int MUL_LO_W     = 16;
  // 0.607252935 in Q24
  localparam logic signed [24:0] GAIN_Q24 = 25'sd10188014;
  localparam int GAIN_SHIFT   = GUARD_BITS + 24;

  typedef enum logic [1:0] {
    REG_CENTER_X     = 2'd0,
    REG_CENTER_Y     = 2'd1,
    REG_ROTATE_ANGLE = 2'd2
  } prac_reg_t;

  typedef logic signed [ANGLE_W-1:0] prac_angle_t;

  // travels beside the data through every stage
  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] index;
  } prac_ctl_t;

  // atan(2^-i), 2^32 per full turn
  function automatic prac_angle_t atan_entry(input int unsigned stage);
    prac_angle_t a;
    unique case (stage)
      0:       a = 32'sh20000000;
      1:       a = 32'sh12E4051E;
      2:       a = 32'sh09FB385B;
      3:       a = 32'sh051111D4;
      4:       a = 32'sh028B0D43;
      5:       a = 32'sh0145D7E1;
      6:       a = 32'sh00A2F61E;
      7:       a = 32'sh00517C55;
      8:       a = 32'sh0028BE53;
      9:       a = 32'sh00145F2F;
      10:      a = 32'sh000A2F98;
      11:      a = 32'sh000517CC;
      12:      a = 32'sh00028BE6;
      13:      a = 32'sh000145F3;
      14:      a = 32'sh0000A2FA;
      15:      a = 32'sh0000517D;
      16:      a = 32'sh000028BE;
      17:      a = 32'sh0000145F;
      18:      a = 32'sh00000A30;
      19:      a = 32'sh00000518;
      20:      a = 32'sh0000028C;
      21:      a = 32'sh00000146;
      22:      a = 32'sh000000A3;
      23:      a = 32'sh00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[sv/prac_cell.sv]
module prac_cell #(
  parameter int XW    = 32,
  parameter int STAGE = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  prac_pkg::prac_ctl_t        ctl_i,
  input  logic signed [XW-1:0]       x_i,
  input  logic signed [XW-1:0]       y_i,
  input  prac_pkg::prac_angle_t      z_i,
  output prac_pkg::prac_ctl_t        ctl_o,
  output logic signed [XW-1:0]       x_o,
  output logic signed [XW-1:0]       y_o,
  output prac_pkg::prac_angle_t      z_o
);

  localparam prac_pkg::prac_angle_t ATAN = prac_pkg::atan_entry(STAGE);

  prac_pkg::prac_ctl_t   ctl_r;
  logic signed [XW-1:0]  x_r, x_nxt;
  logic signed [XW-1:0]  y_r, y_nxt;
  prac_pkg::prac_angle_t z_r, z_nxt;
  logic signed [XW-1:0]  xs, ys;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!z_i[prac_pkg::ANGLE_W-1]) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

[sv/prac_gain.sv]
module prac_gain #(
  parameter int CW = 24,
  parameter int XW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  prac_pkg::prac_ctl_t  ctl_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [CW-1:0] cx,
  input  logic signed [CW-1:0] cy,
  output prac_pkg::prac_ctl_t  ctl_o,
  output logic [CW-1:0]        rx_o,
  output logic [CW-1:0]        ry_o,
  output logic                 sat_o
);

  localparam int LW  = prac_pkg::MUL_LO_W;
  localparam int HW  = XW - LW;
  localparam int PLW = LW + 26;
  localparam int PHW = HW + 25;
  localparam int SW  = XW + 26;
  localparam int OW  = SW - prac_pkg::GAIN_SHIFT;
  localparam int RW  = OW + 1;
  localparam logic signed [SW-1:0] RND = SW'(1) <<< (prac_pkg::GAIN_SHIFT - 1);
  localparam logic signed [RW-1:0] HI  = RW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] LO  = -HI - RW'(1);

  // partial products
  prac_pkg::prac_ctl_t    ctl1_r, ctl2_r, ctl3_r;
  logic signed [PLW-1:0]  xlo_r, xlo_nxt, ylo_r, ylo_nxt;
  logic signed [PHW-1:0]  xhi_r, xhi_nxt, yhi_r, yhi_nxt;
  // rounded offsets
  logic signed [SW-1:0]   xsum, ysum;
  logic signed [OW-1:0]   ox_r, ox_nxt, oy_r, oy_nxt;
  // center added and clamped
  logic signed [RW-1:0]   rx, ry;
  logic [CW-1:0]          rx_r, rx_nxt, ry_r, ry_nxt;
  logic                   sat_r, sat_nxt;
  logic                   sx_hi, sx_lo, sy_hi, sy_lo;

  always_comb begin
    xlo_nxt = $signed({1'b0, x_i[LW-1:0]}) * prac_pkg::GAIN_Q24;
    ylo_nxt = $signed({1'b0, y_i[LW-1:0]}) * prac_pkg::GAIN_Q24;
    xhi_nxt = $signed(x_i[XW-1:LW]) * prac_pkg::GAIN_Q24;
    yhi_nxt = $signed(y_i[XW-1:LW]) * prac_pkg::GAIN_Q24;
  end

  always_comb begin
    xsum   = (SW'(xhi_r) <<< LW) + SW'(xlo_r) + RND;
    ysum   = (SW'(yhi_r) <<< LW) + SW'(ylo_r) + RND;
    ox_nxt = $signed(xsum[SW-1:prac_pkg::GAIN_SHIFT]);
    oy_nxt = $signed(ysum[SW-1:prac_pkg::GAIN_SHIFT]);
  end

  always_comb begin
    rx      = RW'(cx) + RW'(ox_r);
    ry      = RW'(cy) + RW'(oy_r);
    sx_hi   = rx > HI;
    sx_lo   = rx < LO;
    sy_hi   = ry > HI;
    sy_lo   = ry < LO;
    rx_nxt  = sx_hi ? HI[CW-1:0] : (sx_lo ? LO[CW-1:0] : rx[CW-1:0]);
    ry_nxt  = sy_hi ? HI[CW-1:0] : (sy_lo ? LO[CW-1:0] : ry[CW-1:0]);
    sat_nxt = sx_hi | sx_lo | sy_hi | sy_lo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_i;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xlo_r <= xlo_nxt;
      ylo_r <= ylo_nxt;
      xhi_r <= xhi_nxt;
      yhi_r <= yhi_nxt;
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      rx_r  <= rx_nxt;
      ry_r  <= ry_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign ctl_o = ctl3_r;
  assign rx_o  = rx_r;
  assign ry_o  = ry_r;
  assign sat_o = sat_r;

endmodule

[sv/point_rotate_about_center.sv]
// channel | dir | handshake             | payload
// in_     | in  | in_tvalid/in_tready   | in_tdata: point_x, point_y, dot_index
// out_    | out | out_tvalid/out_tready | out_tdata: rotated_x, rotated_y,
//         |     |                       |   dot_index_out; out_tuser: saturated
// cfg_    | in  | psel/penable/pwrite   | center_x @0x0, center_y @0x4,
//         |     |                       |   rotate_angle @0x8
//
// one point per cycle while the output buffer is not full; the path to out_tvalid runs through
// the row of CORDIC cells: one entry stage, one cell per micro-rotation,
// three stages for the split gain multiply, rounding and clamp, then the output buffer
// synchronous active-low reset clears the config registers, the valid bits
// and the two-entry output buffer
// the whole row freezes while the output buffer holds two results
module point_rotate_about_center #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_WIDTH   = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // point_x, point_y, dot_index
  input  logic [((2 * COORD_WIDTH + prac_pkg::INDEX_W + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // rotated_x, rotated_y, dot_index_out
  output logic [((2 * COORD_WIDTH + prac_pkg::INDEX_W + 7) / 8) * 8 - 1:0] out_tdata,
  // saturated
  output logic                              out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [prac_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [prac_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [prac_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int CW    = COORD_WIDTH;
  localparam int IW    = prac_pkg::INDEX_W;
  localparam int OUT_W = ((2 * CW + IW + 7) / 8) * 8;
  localparam int DW    = CW + 1;
  localparam int XW    = CW + 8;
  localparam int AW    = prac_pkg::ANGLE_W;

  typedef struct packed {
    logic [IW-1:0] index;
    logic [CW-1:0] ry;
    logic [CW-1:0] rx;
    logic          sat;
  } prac_item_t;

  // config registers
  logic signed [CW-1:0]               center_x_r, center_y_r;
  logic [prac_pkg::CFG_ANGLE_W-1:0]   angle_r;
  logic                               cfg_wr;

  // entry stage
  logic                               en;
  prac_pkg::prac_angle_t              z_cfg, z0_nxt;
  logic                               flip;
  logic signed [CW-1:0]               px, py;
  logic signed [DW-1:0]               dx, dy;
  logic signed [XW-1:0]               x0_nxt, y0_nxt;

  // cell chain
  prac_pkg::prac_ctl_t                ctl_c [CORDIC_STAGES+1];
  logic signed [XW-1:0]               x_c   [CORDIC_STAGES+1];
  logic signed [XW-1:0]               y_c   [CORDIC_STAGES+1];
  prac_pkg::prac_angle_t              z_c   [CORDIC_STAGES+1];
  prac_pkg::prac_ctl_t                ctl0_r;
  logic signed [XW-1:0]               x0_r, y0_r;
  prac_pkg::prac_angle_t              z0_r;

  // gain and clamp
  prac_pkg::prac_ctl_t                ctl_g;
  logic [CW-1:0]                      rx_g, ry_g;
  logic                               sat_g;

  // output buffer
  prac_item_t                         buf_r [2];
  prac_item_t                         head;
  logic                               wr_ptr_r, wr_ptr_nxt;
  logic                               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                         count_r, count_nxt;
  logic                               push, pop;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      angle_r    <= '0;
    end else if (cfg_wr) begin
      unique case (prac_pkg::prac_reg_t'(cfg_paddr[3:2]))
        prac_pkg::REG_CENTER_X:     center_x_r <= cfg_pwdata[CW-1:0];
        prac_pkg::REG_CENTER_Y:     center_y_r <= cfg_pwdata[CW-1:0];
        prac_pkg::REG_ROTATE_ANGLE: angle_r    <= cfg_pwdata[prac_pkg::CFG_ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (prac_pkg::prac_reg_t'(cfg_paddr[3:2]))
      prac_pkg::REG_CENTER_X:     cfg_prdata = prac_pkg::CFG_DATA_W'($unsigned(center_x_r));
      prac_pkg::REG_CENTER_Y:     cfg_prdata = prac_pkg::CFG_DATA_W'($unsigned(center_y_r));
      prac_pkg::REG_ROTATE_ANGLE: cfg_prdata = prac_pkg::CFG_DATA_W'(angle_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // angles past +-pi/2 take a half turn first: offset negated, msb of z flipped
  always_comb begin
    z_cfg  = {angle_r, {(AW - prac_pkg::CFG_ANGLE_W){1'b0}}};
    flip   = (z_cfg > 32'sh40000000) || (z_cfg < -32'sh40000000);
    z0_nxt = {~z_cfg[AW-1] ^ ~flip, z_cfg[AW-2:0]};
    px     = $signed(in_tdata[CW-1:0]);
    py     = $signed(in_tdata[2*CW-1:CW]);
    dx     = flip ? (DW'(center_x_r) - DW'(px)) : (DW'(px) - DW'(center_x_r));
    dy     = flip ? (DW'(center_y_r) - DW'(py)) : (DW'(py) - DW'(center_y_r));
    x0_nxt = XW'(dx) <<< prac_pkg::GUARD_BITS;
    y0_nxt = XW'(dy) <<< prac_pkg::GUARD_BITS;
  end

  assign en        = (count_r != 2'd2);
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r <= '0;
    end else if (en) begin
      ctl0_r.valid <= in_tvalid;
      ctl0_r.index <= in_tdata[2*CW+IW-1:2*CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= x0_nxt;
      y0_r <= y0_nxt;
      z0_r <= z0_nxt;
    end
  end

  assign ctl_c[0] = ctl0_r;
  assign x_c[0]   = x0_r;
  assign y_c[0]   = y0_r;
  assign z_c[0]   = z0_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    prac_cell #(
      .XW    (XW),
      .STAGE (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl_c[i]),
      .x_i   (x_c[i]),
      .y_i   (y_c[i]),
      .z_i   (z_c[i]),
      .ctl_o (ctl_c[i+1]),
      .x_o   (x_c[i+1]),
      .y_o   (y_c[i+1]),
      .z_o   (z_c[i+1])
    );
  end

  prac_gain #(
    .CW (CW),
    .XW (XW)
  ) u_gain (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (ctl_c[CORDIC_STAGES]),
    .x_i   (x_c[CORDIC_STAGES]),
    .y_i   (y_c[CORDIC_STAGES]),
    .cx    (center_x_r),
    .cy    (center_y_r),
    .ctl_o (ctl_g),
    .rx_o  (rx_g),
    .ry_o  (ry_g),
    .sat_o (sat_g)
  );

  assign push = en & ctl_g.valid;
  assign pop  = out_tvalid & out_tready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= '{index: ctl_g.index, ry: ry_g, rx: rx_g, sat: sat_g};
    end
  end

  assign head       = buf_r[rd_ptr_r];
  assign out_tvalid = (count_r != 2'd0);
  assign out_tdata  = OUT_W'({head.index, head.ry, head.rx});
  assign out_tuser  = head.sat;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("output buffer count out of range");

  a_row_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(ctl_g) && $stable(rx_g) && $stable(ry_g))
    else $error("cell row moved while output buffer full");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> count_r == $past(count_r) - 2'd1)
    else $error("output buffer count did not drop on request taken");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> out_tvalid)
    else $error("pushed result not shown on output");

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     INDEX_W     = prac_pkg::INDEX_W;
  localparam int     CFG_ADDR_W  = prac_pkg::CFG_ADDR_W;
  localparam int     CFG_DATA_W  = prac_pkg::CFG_DATA_W;

  localparam int     STAGES      = 16;
  localparam int     CW          = 24;
  localparam int     ANGLE_ROWS  = 24;
  localparam longint COORD_MAX   = 8388607;
  localparam longint COORD_MIN   = -8388608;
  localparam longint QUARTER     = 64'sd1073741824;   // pi/2 in 2^32-per-turn units
  localparam longint GAIN        = 64'sd10188014;
  localparam longint ROUND_HALF  = 64'sd134217728;    // 2^(guard+23)
  localparam int     OUT_SHIFT   = 28;
  localparam int     UNUSED_REG  = 3;
  localparam int     SETTLE_CYC  = 40;
  localparam int     HOLD_CYCLES = 400;
  localparam int     HOLD_AT     = 300;
  localparam int     PHASES      = 8;
  localparam int     PHASE_ITEMS = 220;
  localparam int     MAX_REPORTS = 20;
  localparam int     LIMIT       = 300000;

  localparam longint ATAN_Q32 [ANGLE_ROWS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  typedef struct packed {
    logic signed [CW-1:0]  rx;
    logic signed [CW-1:0]  ry;
    logic [INDEX_W-1:0]    idx;
    logic                  sat;
  } rot_result_t;

  typedef struct {
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic signed [15:0]    ang;
    logic signed [CW-1:0]  px;
    logic signed [CW-1:0]  py;
    logic [INDEX_W-1:0]    idx;
    bit                    typed;
    rot_result_t           want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // point_x [23:0], point_y [47:24], dot_index [57:48], zero fill
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // rotated_x [23:0], rotated_y [47:24], dot_index_out [57:48], zero fill
  logic [63:0] out_tdata;
  // saturated [0]
  logic        out_tuser;

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // register mirror
  logic signed [CW-1:0] ctr_x = '0;
  logic signed [CW-1:0] ctr_y = '0;
  logic signed [15:0]   rot_ang = '0;

  rot_result_t pending_rot [$];
  stim_row_t   dir_rows [$];

  int     errors = 0;
  int     items_sent = 0;
  int     results_seen = 0;
  int     sat_seen = 0;
  int     settings_used = 0;
  longint cycle_count = 0;
  logic   hold_off = 1'b0;
  int     ready_mode = 0;
  int     mode_left = 0;
  logic   rdy;

  point_rotate_about_center #(
    .CORDIC_STAGES(STAGES),
    .COORD_WIDTH  (CW)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rot_result_t rotate_about_center(logic signed [CW-1:0] px,
                                                      logic signed [CW-1:0] py,
                                                      logic [INDEX_W-1:0] idx);
    rot_result_t r;
    longint cx, cy, x, y, z, xs, ys, vx, vy;
    cx = longint'(ctr_x);
    cy = longint'(ctr_y);
    r.sat = 1'b0;
    if (longint'(px) == cx && longint'(py) == cy) begin
      vx = longint'(px);
      vy = longint'(py);
    end else begin
      x = (longint'(px) - cx) * 16;
      y = (longint'(py) - cy) * 16;
      z = longint'(rot_ang) * 65536;
      // beyond a quarter turn: take half a turn out by negating
      if (z > QUARTER) begin
        x = -x;
        y = -y;
        z = z - 2 * QUARTER;
      end else if (z < -QUARTER) begin
        x = -x;
        y = -y;
        z = z + 2 * QUARTER;
      end
      for (int i = 0; i < STAGES && i < ANGLE_ROWS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_Q32[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_Q32[i];
        end
      end
      vx = cx + ((x * GAIN + ROUND_HALF) >>> OUT_SHIFT);
      vy = cy + ((y * GAIN + ROUND_HALF) >>> OUT_SHIFT);
    end
    if (vx > COORD_MAX) begin vx = COORD_MAX; r.sat = 1'b1; end
    if (vx < COORD_MIN) begin vx = COORD_MIN; r.sat = 1'b1; end
    if (vy > COORD_MAX) begin vy = COORD_MAX; r.sat = 1'b1; end
    if (vy < COORD_MIN) begin vy = COORD_MIN; r.sat = 1'b1; end
    r.rx = vx[CW-1:0];
    r.ry = vy[CW-1:0];
    r.idx = idx;
    return r;
  endfunction

  function automatic void add_row(int cx, int cy, int ang, int px, int py, int idx,
                                  int typed, int erx, int ery, int esat);
    stim_row_t row;
    row.cx = CW'(cx);
    row.cy = CW'(cy);
    row.ang = 16'(ang);
    row.px = CW'(px);
    row.py = CW'(py);
    row.idx = INDEX_W'(idx);
    row.typed = (typed != 0);
    row.want = '{rx: CW'(erx), ry: CW'(ery), idx: INDEX_W'(idx), sat: 1'(esat)};
    dir_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (errors < MAX_REPORTS)
      $display("mismatch: %s got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic write_reg(int idx, logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * idx);
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == prac_pkg::REG_CENTER_X) ctr_x = data[CW-1:0];
    else if (idx == prac_pkg::REG_CENTER_Y) ctr_y = data[CW-1:0];
    else if (idx == prac_pkg::REG_ROTATE_ANGLE) rot_ang = data[15:0];
  endtask

  task automatic read_reg(int idx, output logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= CFG_ADDR_W'(4 * idx);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    data = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic verify_regs();
    logic [CFG_DATA_W-1:0] d;
    read_reg(prac_pkg::REG_CENTER_X, d);
    if (d[CW-1:0] !== ctr_x) report_mismatch("center_x readback", d[CW-1:0], ctr_x);
    read_reg(prac_pkg::REG_CENTER_Y, d);
    if (d[CW-1:0] !== ctr_y) report_mismatch("center_y readback", d[CW-1:0], ctr_y);
    read_reg(prac_pkg::REG_ROTATE_ANGLE, d);
    if (d[15:0] !== rot_ang) report_mismatch("rotate_angle readback", d[15:0], rot_ang);
  endtask

  task automatic apply_config(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                              logic signed [15:0] ang);
    write_reg(prac_pkg::REG_CENTER_X, {{(CFG_DATA_W-CW){cx[CW-1]}}, cx});
    write_reg(prac_pkg::REG_CENTER_Y, {{(CFG_DATA_W-CW){cy[CW-1]}}, cy});
    write_reg(prac_pkg::REG_ROTATE_ANGLE, {{(CFG_DATA_W-16){ang[15]}}, ang});
    verify_regs();
    settings_used++;
  endtask

  // hold the request until the block takes it, then queue what it should return
  task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                            logic [INDEX_W-1:0] idx, rot_result_t want);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(64-2*CW-INDEX_W){1'b0}}, idx, py, px};
    do @(posedge clk); while (in_tready !== 1'b1);
    pending_rot.push_back(want);
    items_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_rot.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      rot_result_t w;
      results_seen++;
      if (out_tuser === 1'b1) sat_seen++;
      if (pending_rot.size() == 0) begin
        report_mismatch("result with nothing pending, x", $signed(out_tdata[CW-1:0]), 0);
      end else begin
        w = pending_rot.pop_front();
        if (out_tdata[CW-1:0] !== w.rx)
          report_mismatch("rotated_x", $signed(out_tdata[CW-1:0]), w.rx);
        if (out_tdata[2*CW-1:CW] !== w.ry)
          report_mismatch("rotated_y", $signed(out_tdata[2*CW-1:CW]), w.ry);
        if (out_tdata[2*CW+INDEX_W-1:2*CW] !== w.idx)
          report_mismatch("dot_index_out", out_tdata[2*CW+INDEX_W-1:2*CW], w.idx);
        if (out_tuser !== w.sat)
          report_mismatch("saturated", out_tuser, w.sat);
      end
    end
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(16, 200);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0:       rdy = 1'b1;
      1:       rdy = 1'($urandom_range(0, 1));
      2:       rdy = ($urandom_range(0, 3) == 0);
      default: rdy = (cycle_count[2:0] != 3'd0);
    endcase
    out_tready <= hold_off ? 1'b0 : rdy;
  end

  // one long receiver hold-off while the sender keeps pushing
  initial begin
    while (items_sent < HOLD_AT) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("timeout with %0d results pending", pending_rot.size());
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    stim_row_t            row;
    rot_result_t          want;
    logic signed [CW-1:0] cx, cy, px, py;
    logic signed [15:0]   ang;
    logic [INDEX_W-1:0]   idx;
    int                   burst_left;
    int                   gap;
    int                   tmp;

    // after reset
    add_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_row(0, 0, 0, 256, 0, 1023, 0, 0, 0, 0);
    add_row(0, 0, 0, 8388607, 8388607, 1, 0, 0, 0, 0);
    add_row(0, 0, 0, -8388608, -8388608, 2, 0, 0, 0, 0);
    // quarter turns and the edges of the half-turn fold
    add_row(0, 0, 16384, 256, 0, 3, 0, 0, 0, 0);
    add_row(0, 0, 16384, 0, -256, 4, 0, 0, 0, 0);
    add_row(0, 0, 16384, 1, 1, 5, 0, 0, 0, 0);
    add_row(0, 0, 32767, 1000, -3000, 6, 0, 0, 0, 0);
    add_row(0, 0, 32767, -1, 0, 7, 0, 0, 0, 0);
    add_row(0, 0, -32768, 5000, 7000, 8, 0, 0, 0, 0);
    add_row(0, 0, 16385, 12345, -54321, 9, 0, 0, 0, 0);
    add_row(0, 0, -16385, -12345, 54321, 10, 0, 0, 0, 0);
    add_row(0, 0, -16384, 4096, 4096, 11, 0, 0, 0, 0);
    // point at and beside the center with the center at a corner
    add_row(8388607, -8388608, 8192, 8388607, -8388608, 1023, 1, 8388607, -8388608, 0);
    add_row(8388607, -8388608, 8192, 8388606, -8388607, 12, 0, 0, 0, 0);
    // half turn across the whole range clamps
    add_row(8388607, 8388607, -32768, -8388608, -8388608, 13, 1, 8388607, 8388607, 1);
    add_row(8388607, 8388607, -32768, 8388607, 8388607, 14, 1, 8388607, 8388607, 0);
    add_row(-8388608, -8388608, -32768, 8388607, 8388607, 15, 1, -8388608, -8388608, 1);
    add_row(-8388608, 8388607, 12000, 8388607, -8388608, 16, 0, 0, 0, 0);
    add_row(-8388608, 8388607, 12000, 0, 0, 512, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    verify_regs();
    settings_used = 1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.cx !== ctr_x || row.cy !== ctr_y || row.ang !== rot_ang) begin
        settle();
        apply_config(row.cx, row.cy, row.ang);
        if (i == 4) begin
          // write to an address past the register list must change nothing
          write_reg(UNUSED_REG, '1);
          verify_regs();
        end
      end
      want = row.typed ? row.want : rotate_about_center(row.px, row.py, row.idx);
      send_point(row.px, row.py, row.idx, want);
    end

    burst_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       ang = 16'sd32767;
        1:       ang = -16'sd32768;
        2:       ang = 16'sd16384;
        3:       ang = -16'sd16384;
        default: ang = 16'($urandom());
      endcase
      case (p % 4)
        0: begin
          cx = CW'($urandom());
          cy = CW'($urandom());
        end
        1: begin
          cx = CW'($urandom_range(0, 2000) - 1000);
          cy = CW'($urandom_range(0, 2000) - 1000);
        end
        2: begin
          cx = $urandom_range(0, 1) ? COORD_MAX[CW-1:0] : COORD_MIN[CW-1:0];
          cy = $urandom_range(0, 1) ? COORD_MAX[CW-1:0] : COORD_MIN[CW-1:0];
        end
        default: begin
          cx = '0;
          cy = '0;
        end
      endcase
      apply_config(cx, cy, ang);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap != 0) begin
            in_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        case ($urandom_range(0, 9))
          5, 6, 7: begin
            // small offset from the center
            tmp = int'(ctr_x) + int'($urandom_range(0, 8192)) - 4096;
            px = tmp[CW-1:0];
            tmp = int'(ctr_y) + int'($urandom_range(0, 8192)) - 4096;
            py = tmp[CW-1:0];
          end
          8: begin
            px = ctr_x;
            py = ctr_y;
          end
          9: begin
            px = $urandom_range(0, 1) ? COORD_MAX[CW-1:0] : COORD_MIN[CW-1:0];
            py = $urandom_range(0, 1) ? COORD_MAX[CW-1:0] : COORD_MIN[CW-1:0];
          end
          default: begin
            px = CW'($urandom());
            py = CW'($urandom());
          end
        endcase
        idx = INDEX_W'($urandom());
        send_point(px, py, idx, rotate_about_center(px, py, idx));
      end
    end

    settle();
    $display("sent %0d points over %0d register settings, %0d results checked",
             items_sent, settings_used, results_seen);
    $display("%0d results clamped, receiver hold-off of %0d cycles included",
             sat_seen, HOLD_CYCLES);
    if (errors == 0 && pending_rot.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
